// ===== sv/point_cloud_running_mean_merge_core_defines.svh =====
// assertion macros for the point cloud running mean merge core
`ifndef POINT_CLOUD_RUNNING_MEAN_MERGE_CORE_DEFINES_SVH
`define POINT_CLOUD_RUNNING_MEAN_MERGE_CORE_DEFINES_SVH

// property that must hold at every clock edge outside reset
`define PCRM_ASSERT(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
        else $error("pcrm assertion failed");

// condition in one cycle implies a condition in the next cycle
`define PCRM_ASSERT_NEXT(label, clk, rstn, cond, conseq) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (cond) |=> (conseq)) \
        else $error("pcrm assertion failed");

`endif

// ===== sv/pcrm_pkg.sv =====
// shared types and constants of the running mean merge core
`default_nettype none

package pcrm_pkg;

    localparam int COORDS      = 3;
    localparam int IDX_W       = 16;
    localparam int COORD_W     = 32;
    localparam int RGB_W       = 24;
    localparam int CNT_W       = 16;
    localparam int SQ_W        = 63;
    localparam int ACC_W       = 49;
    localparam int MAG_W       = 48;
    localparam int D_W         = 17;
    localparam int Q_W         = 32;
    localparam int DIV_STEPS   = 4;
    localparam int DIV_STAGES  = Q_W / DIV_STEPS;
    localparam int PREP_STAGES = 4;

    localparam logic [CNT_W-1:0] COUNT_MAX = '1;
    localparam logic [SQ_W-1:0]  SUMSQ_MAX = '1;

    typedef struct packed {
        logic [CNT_W-1:0]                count;
        logic [COORDS-1:0][COORD_W-1:0]  mean;
        logic [RGB_W-1:0]                colour;
        logic [COORDS-1:0][SQ_W-1:0]     sumsq;
    } entry_t;

    typedef struct packed {
        logic [IDX_W-1:0]                idx;
        logic                            in_range;
        logic                            finite;
        logic [COORDS-1:0][COORD_W-1:0]  coord;
        logic [RGB_W-1:0]                rgb;
    } item_t;

    typedef struct packed {
        item_t                           item;
        entry_t                          old;
        logic [COORDS-1:0][ACC_W-1:0]    acc;
        logic [COORDS-1:0][SQ_W-1:0]     sq;
        logic [COORDS-1:0]               neg;
        logic [COORDS-1:0][D_W-1:0]      rem;
        logic [COORDS-1:0][Q_W-1:0]      quo;
        logic [D_W-1:0]                  divisor;
    } work_t;

    typedef struct packed {
        logic             valid;
        logic [IDX_W-1:0] idx;
    } tag_t;

endpackage

`default_nettype wire

// ===== sv/pcrm_store.sv =====
// per-slot store memory with the clearing pass after reset
`default_nettype none

module pcrm_store #(
    parameter int DEPTH  = 65536,
    parameter int ADDR_W = 16
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output pcrm_pkg::entry_t       rd_data,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire pcrm_pkg::entry_t  wr_data,
    output logic                   clr_busy
);
    import pcrm_pkg::*;

    localparam logic [ADDR_W-1:0] LAST = ADDR_W'(DEPTH - 1);

    entry_t            mem [DEPTH];
    entry_t            rd_data_reg;
    logic [ADDR_W-1:0] clr_cnt_reg;
    logic              clr_busy_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_busy_reg <= 1'b1;
            clr_cnt_reg  <= '0;
        end else if (clr_busy_reg) begin
            if (clr_cnt_reg == LAST) begin
                clr_busy_reg <= 1'b0;
            end
            clr_cnt_reg <= clr_cnt_reg + 1'b1;
        end
    end

    // empty slot = count zero, other fields don't care
    always_ff @(posedge aclk) begin
        if (clr_busy_reg) begin
            mem[clr_cnt_reg] <= '0;
        end else if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data  = rd_data_reg;
    assign clr_busy = clr_busy_reg;

endmodule

`default_nettype wire

// ===== sv/pcrm_prep.sv =====
// front stages: weight product, numerator and squares, rounding and sums
`default_nettype none

module pcrm_prep (
    input  wire logic                                   aclk,
    input  wire logic                                   aresetn,
    input  wire logic                                   in_valid,
    input  wire pcrm_pkg::item_t                        in_item,
    input  wire pcrm_pkg::entry_t                       rd_data,
    output logic                                        in_ready,
    output logic                                        out_valid,
    output pcrm_pkg::work_t                             out_data,
    input  wire logic                                   out_ready,
    output pcrm_pkg::tag_t [pcrm_pkg::PREP_STAGES-1:0]  tags
);
    import pcrm_pkg::*;

    item_t s1_item_reg;
    work_t s1, s2_next, s3_next, s4_next;
    work_t s2_reg, s3_reg, s4_reg;
    logic  v1_reg, v2_reg, v3_reg, v4_reg;
    logic  rdy1, rdy2, rdy3, rdy4;

    assign rdy4     = !v4_reg || out_ready;
    assign rdy3     = !v3_reg || rdy4;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign in_ready = rdy1;

    // stage 1: accepted point plus the slot read out of the store
    always_comb begin
        s1      = '0;
        s1.item = s1_item_reg;
        s1.old  = rd_data;
    end

    // stage 1 -> 2: mean times weight
    always_comb begin
        logic signed [ACC_W-1:0] prod;
        s2_next = s1;
        for (int c = 0; c < COORDS; c++) begin
            prod = $signed(s1.old.mean[c]) * $signed({1'b0, s1.old.count});
            s2_next.acc[c] = prod;
        end
        s2_next.divisor = {1'b0, s1.old.count} + D_W'(1);
    end

    // stage 2 -> 3: numerator and squared coordinate
    always_comb begin
        logic signed [ACC_W-1:0] num;
        logic signed [63:0]      sqf;
        s3_next = s2_reg;
        for (int c = 0; c < COORDS; c++) begin
            num = $signed(s2_reg.acc[c]) + $signed(s2_reg.item.coord[c]);
            sqf = $signed(s2_reg.item.coord[c]) * $signed(s2_reg.item.coord[c]);
            s3_next.acc[c] = num;
            s3_next.sq[c]  = sqf[SQ_W-1:0];
        end
    end

    // stage 3 -> 4: magnitude plus half divisor, saturating sums
    always_comb begin
        logic [ACC_W-1:0] absn;
        logic [MAG_W-1:0] mag;
        logic [D_W-1:0]   half;
        logic [63:0]      sum;
        s4_next = s3_reg;
        half    = s3_reg.divisor >> 1;
        for (int c = 0; c < COORDS; c++) begin
            s4_next.neg[c] = s3_reg.acc[c][ACC_W-1];
            absn = s3_reg.acc[c][ACC_W-1] ? (ACC_W'(0) - s3_reg.acc[c]) : s3_reg.acc[c];
            mag  = absn[MAG_W-1:0] + {{(MAG_W-D_W){1'b0}}, half};
            s4_next.rem[c] = {1'b0, mag[MAG_W-1:Q_W]};
            s4_next.quo[c] = mag[Q_W-1:0];
            sum = {1'b0, s3_reg.old.sumsq[c]} + {1'b0, s3_reg.sq[c]};
            if (s3_reg.old.count == '0) begin
                s4_next.sq[c] = s3_reg.sq[c];
            end else begin
                s4_next.sq[c] = sum[63] ? SUMSQ_MAX : sum[SQ_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else begin
            if (rdy1) begin
                v1_reg <= in_valid;
            end
            if (rdy2) begin
                v2_reg <= v1_reg;
            end
            if (rdy3) begin
                v3_reg <= v2_reg;
            end
            if (rdy4) begin
                v4_reg <= v3_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && rdy1) begin
            s1_item_reg <= in_item;
        end
        if (v1_reg && rdy2) begin
            s2_reg <= s2_next;
        end
        if (v2_reg && rdy3) begin
            s3_reg <= s3_next;
        end
        if (v3_reg && rdy4) begin
            s4_reg <= s4_next;
        end
    end

    assign out_valid = v4_reg;
    assign out_data  = s4_reg;

    assign tags[0] = '{valid: v1_reg, idx: s1_item_reg.idx};
    assign tags[1] = '{valid: v2_reg, idx: s2_reg.item.idx};
    assign tags[2] = '{valid: v3_reg, idx: s3_reg.item.idx};
    assign tags[3] = '{valid: v4_reg, idx: s4_reg.item.idx};

endmodule

`default_nettype wire

// ===== sv/pcrm_div_stage.sv =====
// one pipeline stage of the restoring dividers, a few quotient bits each
`default_nettype none

module pcrm_div_stage (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            in_valid,
    input  wire pcrm_pkg::work_t in_data,
    output logic                 in_ready,
    output logic                 out_valid,
    output pcrm_pkg::work_t      out_data,
    input  wire logic            out_ready,
    output pcrm_pkg::tag_t       tag
);
    import pcrm_pkg::*;

    work_t data_next, data_reg;
    logic  valid_reg;

    always_comb begin
        logic [D_W:0] trial;
        logic         qbit;
        data_next = in_data;
        for (int c = 0; c < COORDS; c++) begin
            for (int s = 0; s < DIV_STEPS; s++) begin
                trial = {data_next.rem[c], data_next.quo[c][Q_W-1]};
                qbit  = (trial >= {1'b0, data_next.divisor});
                if (qbit) begin
                    trial = trial - {1'b0, data_next.divisor};
                end
                data_next.rem[c] = trial[D_W-1:0];
                data_next.quo[c] = {data_next.quo[c][Q_W-2:0], qbit};
            end
        end
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;
    assign tag       = '{valid: valid_reg, idx: data_reg.item.idx};

endmodule

`default_nettype wire

// ===== sv/point_cloud_running_mean_merge_core.sv =====
// top level of the point cloud running mean merge core
`default_nettype none
`include "point_cloud_running_mean_merge_core_defines.svh"

// Merges points of organized clouds into a per-slot running mean. Each
// request carries one point; the reply reports the slot after the update
// (mean x/y/z rounded to nearest, kept colour, saturating count and sums of
// squares). Throughput is one point per cycle as long as no point in flight
// hits the same slot and m_ready does not stall the replies. A point whose
// index matches one still inside the twelve-stage pipeline (four front
// stages plus eight divider stages) waits until that earlier point has
// written back its slot, closing the read-modify-write loop through the
// store. From accept, a point passes the front stages, the divider stages
// and the reply register. After reset a clearing pass writes every slot
// empty, one slot a cycle; no request is taken until it ends.
module point_cloud_running_mean_merge_core #(
    parameter int CLOUD_POINTS = 65536
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    // point requests
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic [15:0]        s_point_index,
    input  wire logic signed [31:0] s_new_x,
    input  wire logic signed [31:0] s_new_y,
    input  wire logic signed [31:0] s_new_z,
    input  wire logic [23:0]        s_new_rgb,
    input  wire logic               s_new_finite,
    // slot replies
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic [15:0]             m_out_index,
    output logic                    m_out_occupied,
    output logic signed [31:0]      m_mean_x_out,
    output logic signed [31:0]      m_mean_y_out,
    output logic signed [31:0]      m_mean_z_out,
    output logic [23:0]             m_colour_out,
    output logic [15:0]             m_count_out,
    output logic [62:0]             m_sumsq_x_out,
    output logic [62:0]             m_sumsq_y_out,
    output logic [62:0]             m_sumsq_z_out
);
    import pcrm_pkg::*;

    localparam int ADDR_W   = (CLOUD_POINTS > 1) ? $clog2(CLOUD_POINTS) : 1;
    localparam int NUM_TAGS = PREP_STAGES + DIV_STAGES;

    // store
    entry_t            rd_data;
    entry_t            wr_data;
    logic              mem_wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic              clr_busy;

    // front end and divider chain
    item_t             in_item;
    logic              accept;
    logic              prep_in_ready;
    logic              hazard;
    tag_t [NUM_TAGS-1:0] tags;
    work_t             div_data  [DIV_STAGES+1];
    logic              div_valid [DIV_STAGES+1];
    logic              div_ready [DIV_STAGES+1];

    // write-back and reply
    work_t             w;
    entry_t            merged;
    entry_t            res;
    logic              do_write;
    logic [CNT_W-1:0]  cnt_inc;
    logic              fin_ready;

    logic              out_valid_reg;
    logic [IDX_W-1:0]  out_index_reg;
    entry_t            out_entry_reg;
    entry_t            report;

    // request side: wait during clearing and on a slot still in flight
    always_comb begin
        in_item          = '0;
        in_item.idx      = s_point_index;
        in_item.in_range = ({16'd0, s_point_index} < 32'(CLOUD_POINTS));
        in_item.finite   = s_new_finite;
        in_item.coord[0] = s_new_x;
        in_item.coord[1] = s_new_y;
        in_item.coord[2] = s_new_z;
        in_item.rgb      = s_new_rgb;
    end

    always_comb begin
        hazard = 1'b0;
        for (int k = 0; k < NUM_TAGS; k++) begin
            if (tags[k].valid && (tags[k].idx == s_point_index)) begin
                hazard = 1'b1;
            end
        end
    end

    assign s_ready = prep_in_ready && !hazard && !clr_busy;
    assign accept  = s_valid && s_ready;

    pcrm_store #(
        .DEPTH  (CLOUD_POINTS),
        .ADDR_W (ADDR_W)
    ) u_store (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .rd_en    (accept),
        .rd_addr  (ADDR_W'(s_point_index)),
        .rd_data  (rd_data),
        .wr_en    (mem_wr_en),
        .wr_addr  (wr_addr),
        .wr_data  (wr_data),
        .clr_busy (clr_busy)
    );

    pcrm_prep u_prep (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (accept),
        .in_item   (in_item),
        .rd_data   (rd_data),
        .in_ready  (prep_in_ready),
        .out_valid (div_valid[0]),
        .out_data  (div_data[0]),
        .out_ready (div_ready[0]),
        .tags      (tags[PREP_STAGES-1:0])
    );

    // divider chain, a few quotient bits per stage
    for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
        pcrm_div_stage u_div (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (div_valid[k]),
            .in_data   (div_data[k]),
            .in_ready  (div_ready[k]),
            .out_valid (div_valid[k+1]),
            .out_data  (div_data[k+1]),
            .out_ready (div_ready[k+1]),
            .tag       (tags[PREP_STAGES+k])
        );
    end

    // final select: empty slot takes the point, occupied slot takes the merge
    assign w = div_data[DIV_STAGES];

    always_comb begin
        cnt_inc = (w.old.count == COUNT_MAX) ? COUNT_MAX : (w.old.count + 1'b1);
        merged  = w.old;
        if (w.old.count == '0) begin
            merged.count  = CNT_W'(1);
            merged.mean   = w.item.coord;
            merged.colour = w.item.rgb;
        end else begin
            merged.count = cnt_inc;
            for (int c = 0; c < COORDS; c++) begin
                merged.mean[c] = w.neg[c] ? (Q_W'(0) - w.quo[c]) : w.quo[c];
            end
        end
        merged.sumsq = w.sq;
    end

    assign do_write  = w.item.in_range && w.item.finite;
    assign res       = do_write ? merged : w.old;
    assign fin_ready = !out_valid_reg || m_ready;
    assign div_ready[DIV_STAGES] = fin_ready;

    // write-back happens as the point moves into the reply register
    assign mem_wr_en = div_valid[DIV_STAGES] && fin_ready && do_write;
    assign wr_addr   = ADDR_W'(w.item.idx);
    assign wr_data   = merged;

    // out-of-range point or a slot still empty after the update reports all zero
    assign report = (w.item.in_range && (res.count != '0)) ? res : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (fin_ready) begin
            out_valid_reg <= div_valid[DIV_STAGES];
        end
    end

    always_ff @(posedge aclk) begin
        if (div_valid[DIV_STAGES] && fin_ready) begin
            out_index_reg <= w.item.idx;
            out_entry_reg <= report;
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_out_index    = out_index_reg;
    assign m_out_occupied = (out_entry_reg.count != '0);
    assign m_mean_x_out   = out_entry_reg.mean[0];
    assign m_mean_y_out   = out_entry_reg.mean[1];
    assign m_mean_z_out   = out_entry_reg.mean[2];
    assign m_colour_out   = out_entry_reg.colour;
    assign m_count_out    = out_entry_reg.count;
    assign m_sumsq_x_out  = out_entry_reg.sumsq[0];
    assign m_sumsq_y_out  = out_entry_reg.sumsq[1];
    assign m_sumsq_z_out  = out_entry_reg.sumsq[2];

    // checks
    `PCRM_ASSERT(a_no_accept_in_clear, aclk, aresetn, (s_valid && s_ready) |-> !clr_busy)
    `PCRM_ASSERT(a_no_accept_on_hazard, aclk, aresetn, (s_valid && s_ready) |-> !hazard)
    `PCRM_ASSERT(a_occupied_matches_count, aclk, aresetn, m_valid |-> (m_out_occupied == (m_count_out != 16'd0)))
    `PCRM_ASSERT_NEXT(a_write_gives_reply, aclk, aresetn, mem_wr_en, m_valid)

endmodule

`default_nettype wire
